>>> src/shared_resource_tracker_top_macros.svh
// assertion macros used by the checker file
`ifndef SHARED_RESOURCE_TRACKER_TOP_MACROS_SVH
`define SHARED_RESOURCE_TRACKER_TOP_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define SRT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srt check failed");

// next-cycle implication, skipped while reset is high
`define SRT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srt check failed");

`endif

>>> src/srt_pkg.sv
`default_nettype none

package srt_pkg;

   localparam int OP_W   = 3;
   localparam int TID_W  = 8;
   localparam int RID_W  = 10;
   localparam int CNT_W  = 11;
   localparam int STAT_W = 2;
   localparam int KIND_W = 2;

   localparam logic [OP_W-1:0] OP_TOUCH   = 3'd0;
   localparam logic [OP_W-1:0] OP_FORCE   = 3'd1;
   localparam logic [OP_W-1:0] OP_COMPACT = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [KIND_W-1:0] KIND_UNSEEN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OWNED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHARED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MAPPED = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_PHASE = 2'd2;

   localparam logic [CNT_W-1:0] COUNT_MAX   = 11'h7FF;
   localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic finish;
      logic clr_step;
      logic cmp_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic phase;
      logic sweep_end;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> src/srt_dpath.sv
`default_nettype none

module srt_dpath import srt_pkg::*; #(
   parameter int ENTRIES     = 1024,
   parameter int THREAD_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_wr_en,
   input  logic [CNT_W-1:0]   csr_wr_data,
   input  logic [OP_W-1:0]    req_op,
   input  logic [TID_W-1:0]   req_tid,
   input  logic [RID_W-1:0]   req_resource_id,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_newly_shared,
   output logic               rsp_found,
   output logic [CNT_W-1:0]   rsp_new_id,
   output logic [CNT_W-1:0]   rsp_shared_count
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int VAL_W = (THREAD_BITS > CNT_W) ? THREAD_BITS : CNT_W;
   localparam int ENT_W = KIND_W + VAL_W;
   localparam int ACT_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int TX_W  = (THREAD_BITS > TID_W) ? THREAD_BITS : TID_W;

   logic [ENT_W-1:0]       mem [ENTRIES];
   logic [ENT_W-1:0]       rdata_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   we;
   logic [IDX_W-1:0]       waddr;
   logic [ENT_W-1:0]       wdata;

   logic [CNT_W-1:0]       count_ff;
   logic [OP_W-1:0]        op_ff;
   logic [THREAD_BITS-1:0] tid_ff;
   logic [RID_W-1:0]       rid_ff;

   logic [IDX_W:0]         cnt_ff, cnt_in;
   logic                   rv_ff, rv_in;
   logic [IDX_W-1:0]       widx_ff;
   logic [CNT_W-1:0]       next_ff, next_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic                   phase_ff, phase_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic                   newly_ff, newly_in;
   logic                   found_ff, found_in;
   logic [CNT_W-1:0]       nid_ff, nid_in;
   logic [CNT_W-1:0]       scount_ff;

   logic [ACT_W-1:0]       count_ext, ent_ext, act_size, rid_ext, req_ext, widx_ext;
   logic [TX_W-1:0]        tid_ext;
   logic                   in_range, cnt_lt;
   logic [KIND_W-1:0]      kind;
   logic [VAL_W-1:0]       value, tid_val;
   logic                   load;

   // active size is min(resource_count, ENTRIES)
   assign count_ext = ACT_W'(count_ff);
   assign ent_ext   = ACT_W'(ENTRIES);
   assign act_size  = (count_ext > ent_ext) ? ent_ext : count_ext;
   assign rid_ext   = ACT_W'(rid_ff);
   assign req_ext   = ACT_W'(req_resource_id);
   assign widx_ext  = ACT_W'(widx_ff);
   assign tid_ext   = TX_W'(req_tid);
   assign in_range  = rid_ext < act_size;
   assign cnt_lt    = cnt_ff < (IDX_W + 1)'(ENTRIES);

   assign kind    = rdata_ff[ENT_W-1 -: KIND_W];
   assign value   = rdata_ff[VAL_W-1:0];
   assign tid_val = VAL_W'(tid_ff);

   assign rd_en   = cmd.accept | (cmd.cmp_step & cnt_lt);
   assign rd_addr = cmd.accept ? req_ext[IDX_W-1:0] : cnt_ff[IDX_W-1:0];

   always_comb begin
      we        = 1'b0;
      waddr     = cnt_ff[IDX_W-1:0];
      wdata     = {KIND_UNSEEN, VAL_W'(0)};
      cnt_in    = cnt_ff;
      rv_in     = rv_ff;
      next_in   = next_ff;
      total_in  = total_ff;
      phase_in  = phase_ff;
      load      = 1'b0;
      status_in = STATUS_OK;
      newly_in  = 1'b0;
      found_in  = 1'b0;
      nid_in    = '0;

      if (cmd.accept) begin
         cnt_in  = '0;
         rv_in   = 1'b0;
         next_in = CNT_W'(1);
      end

      if (cmd.clr_step) begin
         we     = 1'b1;
         cnt_in = cnt_ff + (IDX_W + 1)'(1);
      end

      // compaction walk: read one entry ahead, rewrite the one read last cycle
      if (cmd.cmp_step) begin
         rv_in = cnt_lt;
         if (cnt_lt) begin
            cnt_in = cnt_ff + (IDX_W + 1)'(1);
         end
         if (rv_ff) begin
            we    = 1'b1;
            waddr = widx_ff;
            if (kind == KIND_SHARED && widx_ext < act_size) begin
               wdata   = {KIND_MAPPED, VAL_W'(next_ff)};
               next_in = next_ff + CNT_W'(1);
            end
         end
      end

      if (cmd.finish) begin
         load = 1'b1;
         if (op_ff == OP_CLEAR) begin
            total_in = '0;
            phase_in = 1'b0;
         end else begin
            if (act_size != '0) begin
               total_in = next_ff;
            end
            phase_in = 1'b1;
         end
      end

      if (cmd.exec) begin
         load  = 1'b1;
         waddr = rid_ext[IDX_W-1:0];
         case (op_ff)
            OP_TOUCH, OP_FORCE: begin
               if (phase_ff) begin
                  status_in = STATUS_PHASE;
               end else if (!in_range) begin
                  status_in = STATUS_RANGE;
               end else if (op_ff == OP_FORCE) begin
                  we    = 1'b1;
                  wdata = {KIND_SHARED, VAL_W'(0)};
               end else if (kind == KIND_UNSEEN) begin
                  we    = 1'b1;
                  wdata = {KIND_OWNED, tid_val};
               end else if (kind == KIND_OWNED && value != tid_val) begin
                  we       = 1'b1;
                  wdata    = {KIND_SHARED, VAL_W'(0)};
                  newly_in = 1'b1;
                  if (total_ff != COUNT_MAX) begin
                     total_in = total_ff + CNT_W'(1);
                  end
               end
            end
            OP_LOOKUP: begin
               if (!phase_ff) begin
                  status_in = STATUS_PHASE;
               end else if (!in_range) begin
                  status_in = STATUS_RANGE;
               end else if (kind == KIND_MAPPED) begin
                  found_in = 1'b1;
                  nid_in   = value[CNT_W-1:0];
               end
            end
            // compact in the mapped phase and undefined codes
            default: begin
               status_in = STATUS_PHASE;
            end
         endcase
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
         total_ff     <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         cnt_ff       <= cnt_in;
         rv_ff        <= rv_in;
         total_ff     <= total_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff <= next_in;
      widx_ff <= cnt_ff[IDX_W-1:0];
      if (cmd.accept) begin
         op_ff  <= req_op;
         tid_ff <= tid_ext[THREAD_BITS-1:0];
         rid_ff <= req_resource_id;
      end
      if (load) begin
         status_ff <= status_in;
         newly_ff  <= newly_in;
         found_ff  <= found_in;
         nid_ff    <= nid_in;
         scount_ff <= total_in;
      end
   end

   assign stat.phase     = phase_ff;
   assign stat.sweep_end = (cnt_ff == (IDX_W + 1)'(ENTRIES)) && !rv_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_newly_shared = newly_ff;
   assign rsp_found        = found_ff;
   assign rsp_new_id       = nid_ff;
   assign rsp_shared_count = scount_ff;

endmodule

`default_nettype wire

>>> src/srt_ctrl.sv
`default_nettype none

module srt_ctrl import srt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   input  stat_type        stat,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_CLR  = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT, ST_CLR: begin
            if (stat.sweep_end) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_CLEAR) begin
                  state_in = ST_CLR;
               end else if (req_op == OP_COMPACT && !stat.phase) begin
                  state_in = ST_CMP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (stat.sweep_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.cmp_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/shared_resource_tracker_top.sv
// shared resource tracker
// req channel (valid/ready) carries one item: op, tid, resource_id.
// rsp channel (valid/ready) returns exactly one result item per request item,
// in order: status, newly_shared, found, new_id, shared_count.
// csr_wr_en/csr_wr_data write resource_count at once; write only while idle.
// touch, force, lookup and rejected ops: the entry is read at the request edge
// and the result is registered once the output register is free; req_ready
// stays low until then, so no new item is taken before the write-back.
// compact walks the whole table, one entry per cycle.
// clear rewrites every entry, one per cycle.
// after reset a clearing pass runs with req_ready low;
// resource_count returns to 1024, the count to 0 and the phase to marking.
// a result waits in its output register while rsp_ready is low; the next
// item is still accepted and worked on up to the point of its own result.
`default_nettype none

module shared_resource_tracker_top import srt_pkg::*; #(
   parameter int ENTRIES     = 1024,
   parameter int THREAD_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_op,
   input  logic [TID_W-1:0]   req_tid,
   input  logic [RID_W-1:0]   req_resource_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_newly_shared,
   output logic               rsp_found,
   output logic [CNT_W-1:0]   rsp_new_id,
   output logic [CNT_W-1:0]   rsp_shared_count,
   input  logic               csr_wr_en,
   input  logic [CNT_W-1:0]   csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   srt_dpath #(
      .ENTRIES     (ENTRIES),
      .THREAD_BITS (THREAD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_op           (req_op),
      .req_tid          (req_tid),
      .req_resource_id  (req_resource_id),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_newly_shared (rsp_newly_shared),
      .rsp_found        (rsp_found),
      .rsp_new_id       (rsp_new_id),
      .rsp_shared_count (rsp_shared_count)
   );

endmodule

`default_nettype wire

>>> src/srt_check.sv
`default_nettype none
`include "shared_resource_tracker_top_macros.svh"

module srt_check import srt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [STAT_W-1:0]  rsp_status,
   input logic               rsp_newly_shared,
   input logic               rsp_found,
   input logic [CNT_W-1:0]   rsp_new_id,
   input logic [CNT_W-1:0]   rsp_shared_count
);

   // a found lookup is never also a touch result or an error
   `SRT_ASSERT_IMP(a_found_ok, clock, reset, rsp_valid && rsp_found,
      rsp_status == STATUS_OK && !rsp_newly_shared)

   // a fresh share is a good touch and is counted
   `SRT_ASSERT_IMP(a_newly_counted, clock, reset, rsp_valid && rsp_newly_shared,
      rsp_status == STATUS_OK && rsp_shared_count != '0)

   // new id only comes with a hit
   `SRT_ASSERT_IMP(a_id_needs_hit, clock, reset, rsp_valid && !rsp_found,
      rsp_new_id == '0)

   // one item in work at a time
   `SRT_ASSERT_NXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)

   `SRT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_shared_count))

endmodule

bind shared_resource_tracker_top srt_check u_check (.*);

`default_nettype wire
